/* hw/rtl/scu_pkg.sv */
// shared constants, types and the arctangent table of the unbalance unit
`timescale 1ns / 1ps
package scu_pkg;
	localparam int MAG_BITS      = 24;
	localparam int ANGLE_BITS    = 16;
	localparam int CORDIC_STAGES = 18;
	localparam int GUARD_BITS    = 6;
	localparam int RATIO_BITS    = 20;
	localparam int DIV_STAGES    = RATIO_BITS;
	localparam int IDX_BITS      = 5;
	// rotation datapath, angle residue, vectoring datapath and product widths
	localparam int RW = MAG_BITS + GUARD_BITS + 4;
	localparam int ZW = 33;
	localparam int VW = RW + 4;
	localparam int PW = RW + 24;
	localparam logic [19:0] SQ3H_Q20 = 20'd908093;
	localparam logic [18:0] OUT_SCALE_Q22 = 19'd515558;
	localparam logic [RATIO_BITS-1:0] RATIO_MAX = {RATIO_BITS{1'b1}};

	// side data that travels beside the divider cells
	typedef struct packed {
		logic [MAG_BITS-1:0] pos;
		logic [MAG_BITS-1:0] neg;
		logic [MAG_BITS-1:0] zer;
		logic                inf;
		logic                clip_z;
		logic                clip_n;
	} side_t;

	// atan(2^-i) with a full turn of 2^32
	function automatic logic [31:0] atan_val(input logic [IDX_BITS-1:0] i);
		logic [31:0] v;
		case (i)
			5'd0:  v = 32'd536870912;
			5'd1:  v = 32'd316933406;
			5'd2:  v = 32'd167458907;
			5'd3:  v = 32'd85004756;
			5'd4:  v = 32'd42667331;
			5'd5:  v = 32'd21354465;
			5'd6:  v = 32'd10679838;
			5'd7:  v = 32'd5340245;
			5'd8:  v = 32'd2670163;
			5'd9:  v = 32'd1335087;
			5'd10: v = 32'd667544;
			5'd11: v = 32'd333772;
			5'd12: v = 32'd166886;
			5'd13: v = 32'd83443;
			5'd14: v = 32'd41722;
			5'd15: v = 32'd20861;
			5'd16: v = 32'd10430;
			5'd17: v = 32'd5215;
			5'd18: v = 32'd2608;
			5'd19: v = 32'd1304;
			5'd20: v = 32'd652;
			5'd21: v = 32'd326;
			5'd22: v = 32'd163;
			5'd23: v = 32'd81;
			5'd24: v = 32'd41;
			5'd25: v = 32'd20;
			5'd26: v = 32'd10;
			5'd27: v = 32'd5;
			5'd28: v = 32'd3;
			5'd29: v = 32'd1;
			default: v = 32'd0;
		endcase
		return v;
	endfunction
endpackage

/* hw/rtl/scu_rot_cell.sv */
// one micro-rotation of the polar to rectangular cordic
`timescale 1ns / 1ps
module scu_rot_cell import scu_pkg::*; (
	input  logic                 clk,
	input  logic                 en,
	input  logic [IDX_BITS-1:0]  stage,
	input  logic signed [RW-1:0] x_in,
	input  logic signed [RW-1:0] y_in,
	input  logic signed [ZW-1:0] z_in,
	input  logic [1:0]           quad_in,
	output logic signed [RW-1:0] x_out,
	output logic signed [RW-1:0] y_out,
	output logic signed [ZW-1:0] z_out,
	output logic [1:0]           quad_out
);
	logic signed [RW-1:0] dx, dy;
	logic signed [ZW-1:0] t;

	// shifted terms and the angle step of this cell
	always_comb begin
		dx = y_in >>> stage;
		dy = x_in >>> stage;
		t  = signed'({1'b0, atan_val(stage)});
	end

	// rotate toward zero residue
	always_ff @(posedge clk) begin
		if (en) begin
			if (!z_in[ZW-1]) begin
				x_out <= x_in - dx;
				y_out <= y_in + dy;
				z_out <= z_in - t;
			end else begin
				x_out <= x_in + dx;
				y_out <= y_in - dy;
				z_out <= z_in + t;
			end
			quad_out <= quad_in;
		end
	end
endmodule

/* hw/rtl/scu_vec_cell.sv */
// one micro-rotation of the magnitude cordic
`timescale 1ns / 1ps
module scu_vec_cell import scu_pkg::*; (
	input  logic                 clk,
	input  logic                 en,
	input  logic [IDX_BITS-1:0]  stage,
	input  logic signed [VW-1:0] x_in,
	input  logic signed [VW-1:0] y_in,
	output logic signed [VW-1:0] x_out,
	output logic signed [VW-1:0] y_out
);
	logic signed [VW-1:0] dx, dy;

	// shifted terms from the values before the update
	always_comb begin
		dx = y_in >>> stage;
		dy = x_in >>> stage;
	end

	// rotate toward the x axis
	always_ff @(posedge clk) begin
		if (en) begin
			if (!y_in[VW-1]) begin
				x_out <= x_in + dx;
				y_out <= y_in - dy;
			end else begin
				x_out <= x_in - dx;
				y_out <= y_in + dy;
			end
		end
	end
endmodule

/* hw/rtl/scu_div_cell.sv */
// one quotient bit of the restoring ratio divider
`timescale 1ns / 1ps
module scu_div_cell import scu_pkg::*; (
	input  logic                  clk,
	input  logic                  en,
	input  logic [IDX_BITS-1:0]   bit_idx,
	input  logic [MAG_BITS-1:0]   num_in,
	input  logic [MAG_BITS-1:0]   den_in,
	input  logic [MAG_BITS-1:0]   rem_in,
	input  logic [RATIO_BITS-1:0] quo_in,
	output logic [MAG_BITS-1:0]   num_out,
	output logic [MAG_BITS-1:0]   den_out,
	output logic [MAG_BITS-1:0]   rem_out,
	output logic [RATIO_BITS-1:0] quo_out
);
	logic [IDX_BITS-1:0] sh;
	logic                nb;
	logic [MAG_BITS:0]   rt, diff;
	logic                ge;

	// dividend is num shifted up by 16, so only its top bits bring in ones
	always_comb begin
		sh   = bit_idx - IDX_BITS'(16);
		nb   = (bit_idx >= IDX_BITS'(16)) ? num_in[sh] : 1'b0;
		rt   = {rem_in, nb};
		diff = rt - {1'b0, den_in};
		ge   = rt >= {1'b0, den_in};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_out <= num_in;
			den_out <= den_in;
			rem_out <= ge ? diff[MAG_BITS-1:0] : rt[MAG_BITS-1:0];
			quo_out <= {quo_in[RATIO_BITS-2:0], ge};
		end
	end
endmodule

/* hw/rtl/symmetrical_components_unbalance_unit.sv */
// top level: symmetrical components, sequence magnitudes and unbalance ratios
`timescale 1ns / 1ps
// Takes one three-phase phasor set per cycle and returns the positive, negative
// and zero sequence magnitudes with the zero/positive and negative/positive
// ratios in Q4.16. The pipeline is fully streamed: a new item can be accepted
// every cycle while the output is not stalled, and a result passes through
// 18 rotation cells, 5 combining stages, 18 magnitude cells, 3 scaling and
// compare stages, 20 divider cells and the output register. Backpressure on
// the output stalls the whole pipeline. The threshold register sits at byte
// address 0 and should be written only while no item is in flight.
module symmetrical_components_unbalance_unit import scu_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// mag_a, angle_a, mag_b, angle_b, mag_c, angle_c
	input  logic [119:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// positive_mag, negative_mag, zero_mag, zero_ratio, negative_ratio
	output logic [111:0] m_axis_tdata,
	// ratio_infinite, ratio_clipped
	output logic [1:0]   m_axis_tuser,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	localparam int LAT = CORDIC_STAGES * 2 + 5 + 3 + DIV_STAGES;

	logic                en;
	logic [LAT-1:0]      vld_q;
	logic                out_valid_q;
	logic [MAG_BITS-1:0] thr_q;

	assign en            = !out_valid_q || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = out_valid_q;
	assign pready        = 1'b1;
	assign prdata        = {{(32-MAG_BITS){1'b0}}, thr_q};

	// threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= MAG_BITS'(1);
		end else if (psel && penable && pwrite && !paddr[2]) begin
			thr_q <= pwdata[MAG_BITS-1:0];
		end
	end

	// item valid marks moving with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			vld_q       <= {vld_q[LAT-2:0], s_axis_tvalid};
			out_valid_q <= vld_q[LAT-1];
		end
	end

	// rotation chains, one per phase
	logic [MAG_BITS-1:0]   in_mag [3];
	logic [ANGLE_BITS-1:0] in_ang [3];
	logic signed [RW-1:0]  rx [3][CORDIC_STAGES+1];
	logic signed [RW-1:0]  ry [3][CORDIC_STAGES+1];
	logic signed [ZW-1:0]  rz [3][CORDIC_STAGES+1];
	logic [1:0]            rq [3][CORDIC_STAGES+1];

	genvar p, k;
	generate
		for (p = 0; p < 3; p++) begin : g_phase
			assign in_mag[p] = s_axis_tdata[p*(MAG_BITS+ANGLE_BITS) +: MAG_BITS];
			assign in_ang[p] = s_axis_tdata[p*(MAG_BITS+ANGLE_BITS)+MAG_BITS +: ANGLE_BITS];
			assign rx[p][0]  = signed'({{(RW-MAG_BITS-GUARD_BITS){1'b0}}, in_mag[p],
				{GUARD_BITS{1'b0}}});
			assign ry[p][0]  = '0;
			assign rz[p][0]  = signed'({3'b000, in_ang[p][ANGLE_BITS-3:0],
				{(32-ANGLE_BITS){1'b0}}});
			assign rq[p][0]  = in_ang[p][ANGLE_BITS-1 -: 2];
			for (k = 0; k < CORDIC_STAGES; k++) begin : g_rot
				scu_rot_cell u_cell (
					.clk      (clk),
					.en       (en),
					.stage    (IDX_BITS'(k)),
					.x_in     (rx[p][k]),
					.y_in     (ry[p][k]),
					.z_in     (rz[p][k]),
					.quad_in  (rq[p][k]),
					.x_out    (rx[p][k+1]),
					.y_out    (ry[p][k+1]),
					.z_out    (rz[p][k+1]),
					.quad_out (rq[p][k+1])
				);
			end
		end
	endgenerate

	// quadrant correction
	logic signed [RW-1:0] qx_s1 [3];
	logic signed [RW-1:0] qy_s1 [3];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				unique case (rq[i][CORDIC_STAGES])
					2'd1: begin
						qx_s1[i] <= -ry[i][CORDIC_STAGES];
						qy_s1[i] <= rx[i][CORDIC_STAGES];
					end
					2'd2: begin
						qx_s1[i] <= -rx[i][CORDIC_STAGES];
						qy_s1[i] <= -ry[i][CORDIC_STAGES];
					end
					2'd3: begin
						qx_s1[i] <= ry[i][CORDIC_STAGES];
						qy_s1[i] <= -rx[i][CORDIC_STAGES];
					end
					default: begin
						qx_s1[i] <= rx[i][CORDIC_STAGES];
						qy_s1[i] <= ry[i][CORDIC_STAGES];
					end
				endcase
			end
		end
	end

	// sums and differences of phases b and c
	logic signed [RW:0] xa_s2, ya_s2, sx_s2, sy_s2, dx_s2, dy_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			xa_s2 <= (RW+1)'(qx_s1[0]);
			ya_s2 <= (RW+1)'(qy_s1[0]);
			sx_s2 <= (RW+1)'(qx_s1[1]) + (RW+1)'(qx_s1[2]);
			sy_s2 <= (RW+1)'(qy_s1[1]) + (RW+1)'(qy_s1[2]);
			dx_s2 <= (RW+1)'(qx_s1[1]) - (RW+1)'(qx_s1[2]);
			dy_s2 <= (RW+1)'(qy_s1[1]) - (RW+1)'(qy_s1[2]);
		end
	end

	// sqrt(3)/2 products, the common real and imaginary base terms and the zero sequence sums
	logic signed [PW-1:0] sdx_s3, sdy_s3, bre_s3, bim_s3;
	logic signed [VW-1:0] zx_s3, zy_s3;
	logic signed [PW-1:0] s_coef;
	assign s_coef = signed'(PW'(SQ3H_Q20));
	always_ff @(posedge clk) begin
		if (en) begin
			sdx_s3 <= s_coef * PW'(dx_s2);
			sdy_s3 <= s_coef * PW'(dy_s2);
			bre_s3 <= (PW'(xa_s2) <<< 20) - (PW'(sx_s2) <<< 19) + PW'(1 << 19);
			bim_s3 <= (PW'(ya_s2) <<< 20) - (PW'(sy_s2) <<< 19) + PW'(1 << 19);
			zx_s3  <= VW'(xa_s2) + VW'(sx_s2);
			zy_s3  <= VW'(ya_s2) + VW'(sy_s2);
		end
	end

	// positive and negative sequence with rounding, zero sequence passed along
	logic signed [PW-1:0] pre_w, pim_w, nre_w, nim_w;
	logic signed [VW-1:0] vx_s4 [3];
	logic signed [VW-1:0] vy_s4 [3];
	always_comb begin
		pre_w = (bre_s3 - sdy_s3) >>> 20;
		pim_w = (bim_s3 + sdx_s3) >>> 20;
		nre_w = (bre_s3 + sdy_s3) >>> 20;
		nim_w = (bim_s3 - sdx_s3) >>> 20;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			vx_s4[0] <= pre_w[VW-1:0];
			vy_s4[0] <= pim_w[VW-1:0];
			vx_s4[1] <= nre_w[VW-1:0];
			vy_s4[1] <= nim_w[VW-1:0];
			vx_s4[2] <= zx_s3;
			vy_s4[2] <= zy_s3;
		end
	end

	// fold into the right half plane, then the magnitude chains
	logic signed [VW-1:0] vfx_s5 [3];
	logic signed [VW-1:0] vfy_s5 [3];
	logic signed [VW-1:0] vx [3][CORDIC_STAGES+1];
	logic signed [VW-1:0] vy [3][CORDIC_STAGES+1];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				vfx_s5[i] <= vx_s4[i][VW-1] ? -vx_s4[i] : vx_s4[i];
				vfy_s5[i] <= vx_s4[i][VW-1] ? -vy_s4[i] : vy_s4[i];
			end
		end
	end

	generate
		for (p = 0; p < 3; p++) begin : g_seq
			assign vx[p][0] = vfx_s5[p];
			assign vy[p][0] = vfy_s5[p];
			for (k = 0; k < CORDIC_STAGES; k++) begin : g_vec
				scu_vec_cell u_cell (
					.clk   (clk),
					.en    (en),
					.stage (IDX_BITS'(k)),
					.x_in  (vx[p][k]),
					.y_in  (vy[p][k]),
					.x_out (vx[p][k+1]),
					.y_out (vy[p][k+1])
				);
			end
		end
	endgenerate

	// gain correction and division by three
	logic [VW+17:0] sc_m1 [3];
	logic [VW-2:0]  mclamp [3];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mclamp[i] = vx[i][CORDIC_STAGES][VW-1] ? '0 : vx[i][CORDIC_STAGES][VW-2:0];
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sc_m1[i] <= (VW+18)'(mclamp[i]) * (VW+18)'(OUT_SCALE_Q22);
			end
		end
	end

	// round, shift down and saturate
	logic [MAG_BITS-1:0] mag_m2 [3];
	logic [VW+17:0]      rnd [3];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rnd[i] = (sc_m1[i] + (VW+18)'(1 << 27)) >> 28;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				mag_m2[i] <= (rnd[i] > (VW+18)'({MAG_BITS{1'b1}})) ? {MAG_BITS{1'b1}}
					: rnd[i][MAG_BITS-1:0];
			end
		end
	end

	// threshold test, saturation test of both ratios and side data beside the divider
	side_t side [DIV_STAGES+1];
	always_ff @(posedge clk) begin
		if (en) begin
			side[0].pos    <= mag_m2[0];
			side[0].neg    <= mag_m2[1];
			side[0].zer    <= mag_m2[2];
			side[0].inf    <= mag_m2[0] <= thr_q;
			side[0].clip_z <= {4'b0000, mag_m2[2]} >= {mag_m2[0], 4'b0000};
			side[0].clip_n <= {4'b0000, mag_m2[1]} >= {mag_m2[0], 4'b0000};
			for (int i = 0; i < DIV_STAGES; i++) begin
				side[i+1] <= side[i];
			end
		end
	end

	// divider cells, one chain per ratio
	logic [MAG_BITS-1:0]   dnum [2][DIV_STAGES+1];
	logic [MAG_BITS-1:0]   dden [2][DIV_STAGES+1];
	logic [MAG_BITS-1:0]   drem [2][DIV_STAGES+1];
	logic [RATIO_BITS-1:0] dquo [2][DIV_STAGES+1];

	assign dnum[0][0] = side[0].zer;
	assign dnum[1][0] = side[0].neg;
	generate
		for (p = 0; p < 2; p++) begin : g_ratio
			assign dden[p][0] = side[0].pos;
			assign drem[p][0] = dnum[p][0] >> 4;
			assign dquo[p][0] = '0;
			for (k = 0; k < DIV_STAGES; k++) begin : g_div
				scu_div_cell u_cell (
					.clk     (clk),
					.en      (en),
					.bit_idx (IDX_BITS'(DIV_STAGES - 1 - k)),
					.num_in  (dnum[p][k]),
					.den_in  (dden[p][k]),
					.rem_in  (drem[p][k]),
					.quo_in  (dquo[p][k]),
					.num_out (dnum[p][k+1]),
					.den_out (dden[p][k+1]),
					.rem_out (drem[p][k+1]),
					.quo_out (dquo[p][k+1])
				);
			end
		end
	endgenerate

	// output register
	side_t                 fin;
	logic [RATIO_BITS-1:0] zr_q, nr_q;
	logic                  inf_q, clip_q;
	logic [MAG_BITS-1:0]   pos_q, neg_q, zer_q;
	assign fin = side[DIV_STAGES];
	always_ff @(posedge clk) begin
		if (en) begin
			pos_q  <= fin.pos;
			neg_q  <= fin.neg;
			zer_q  <= fin.zer;
			inf_q  <= fin.inf;
			clip_q <= !fin.inf && (fin.clip_z || fin.clip_n);
			zr_q   <= fin.inf ? '0 : (fin.clip_z ? RATIO_MAX : dquo[0][DIV_STAGES]);
			nr_q   <= fin.inf ? '0 : (fin.clip_n ? RATIO_MAX : dquo[1][DIV_STAGES]);
		end
	end

	assign m_axis_tdata = {nr_q, zr_q, zer_q, neg_q, pos_q};
	assign m_axis_tuser = {clip_q, inf_q};
endmodule
